// File: design/gbcd_pkg.sv
package gbcd_pkg;

   // Result codes carried on the encoding field.
   typedef enum logic [1:0] {
      ENC_GB18030 = 2'd0,
      ENC_GBK     = 2'd1,
      ENC_UTF8    = 2'd2
   } encoding_type;

   // Position of the GB18030 checker inside a multi-byte unit.
   typedef enum logic [3:0] {
      PH_LEAD   = 4'b0001,
      PH_TRAIL  = 4'b0010,
      PH_THIRD  = 4'b0100,
      PH_FOURTH = 4'b1000
   } gb_phase_type;

   // Complete state of both validators between beats.
   typedef struct packed {
      gb_phase_type gb_phase;
      logic [7:0]   gb_lead;
      logic         gb_good;
      logic         gbk_pending;
      logic         gbk_good;
   } val_state_type;

   localparam val_state_type VAL_STATE_RESET = '{
      gb_phase:    PH_LEAD,
      gb_lead:     8'h00,
      gb_good:     1'b1,
      gbk_pending: 1'b0,
      gbk_good:    1'b1
   };

   function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

endpackage

// File: design/gbcd_validate.sv
module gbcd_validate (
   input  gbcd_pkg::val_state_type cur_state,
   input  logic [7:0]              data_byte,
   output gbcd_pkg::val_state_type next_state,
   output gbcd_pkg::encoding_type  verdict
);
   import gbcd_pkg::*;

   logic pair_ok;
   logic four_lead;

   // Two-byte GB18030 pairs and the leads that may open a four-byte unit.
   assign pair_ok =
      (in_range(cur_state.gb_lead, 8'hB0, 8'hF7) && in_range(data_byte, 8'hA1, 8'hFE)) ||
      (in_range(cur_state.gb_lead, 8'h81, 8'hA0) && in_range(data_byte, 8'h40, 8'hFE)) ||
      (in_range(cur_state.gb_lead, 8'hAA, 8'hFE) && in_range(data_byte, 8'h40, 8'hA0));
   assign four_lead = in_range(cur_state.gb_lead, 8'h81, 8'h82) ||
                      in_range(cur_state.gb_lead, 8'h95, 8'h98);

   always_comb begin
      next_state = cur_state;

      if (cur_state.gb_good) begin
         unique case (cur_state.gb_phase)
            PH_LEAD: begin
               if (data_byte <= 8'h7F) begin
                  next_state.gb_phase = PH_LEAD;
               end else if (in_range(data_byte, 8'h81, 8'hA0) ||
                            in_range(data_byte, 8'hAA, 8'hFE)) begin
                  next_state.gb_lead  = data_byte;
                  next_state.gb_phase = PH_TRAIL;
               end else begin
                  next_state.gb_good = 1'b0;
               end
            end
            PH_TRAIL: begin
               if (pair_ok) begin
                  next_state.gb_phase = PH_LEAD;
               end else if (four_lead && in_range(data_byte, 8'h30, 8'h39)) begin
                  next_state.gb_phase = PH_THIRD;
               end else begin
                  next_state.gb_good = 1'b0;
               end
            end
            PH_THIRD: begin
               if (in_range(data_byte, 8'h81, 8'hFE)) begin
                  next_state.gb_phase = PH_FOURTH;
               end else begin
                  next_state.gb_good = 1'b0;
               end
            end
            PH_FOURTH: begin
               if (in_range(data_byte, 8'h30, 8'h39)) begin
                  next_state.gb_phase = PH_LEAD;
               end else begin
                  next_state.gb_good = 1'b0;
               end
            end
            default: begin
               next_state.gb_good = 1'b0;
            end
         endcase
      end

      if (cur_state.gbk_good) begin
         if (!cur_state.gbk_pending) begin
            if (data_byte <= 8'h7F) begin
               next_state.gbk_pending = 1'b0;
            end else if (in_range(data_byte, 8'h81, 8'hFE)) begin
               next_state.gbk_pending = 1'b1;
            end else begin
               next_state.gbk_good = 1'b0;
            end
         end else begin
            if (in_range(data_byte, 8'h40, 8'hFE) && (data_byte != 8'h7F)) begin
               next_state.gbk_pending = 1'b0;
            end else begin
               next_state.gbk_good = 1'b0;
            end
         end
      end
   end

   // Verdict if this byte ends the string: an unfinished unit counts as failure.
   always_comb begin
      priority if (next_state.gb_good && (next_state.gb_phase == PH_LEAD)) begin
         verdict = ENC_GB18030;
      end else if (next_state.gbk_good && !next_state.gbk_pending) begin
         verdict = ENC_GBK;
      end else begin
         verdict = ENC_UTF8;
      end
   end

endmodule

// File: design/gb_charset_detector_unit.sv
// Channel   Direction  Ports                                   Beat
// req       in         req_valid/ready, data_byte, last_byte   one byte of a string
// rsp       out        rsp_valid/ready, encoding               one verdict per string
//
// One byte is accepted per cycle while req_ready is high; the verdict for a string
// appears in the result register in the cycle after its last byte is accepted.
// The rate is set by the single state update of both validators per byte.
// Reset is synchronous and active high; it clears the validator state and
// drops rsp_valid.
// A stalled verdict holds; req_ready stays high while the result register is
// empty or being drained in the same cycle.
module gb_charset_detector_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gbcd_pkg::encoding_type rsp_encoding
);
   import gbcd_pkg::*;

   val_state_type state_ff;
   val_state_type state_in;
   val_state_type after_byte;
   encoding_type  verdict;
   encoding_type  encoding_ff;
   encoding_type  encoding_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_accept;

   // The combinational update of both validators for the incoming byte.
   gbcd_validate u_validate (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .next_state (after_byte),
      .verdict    (verdict)
   );

   // A new byte is taken whenever the result register can take a verdict.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      encoding_in  = encoding_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         if (req_last_byte) begin
            // The string ends here: emit the verdict and rearm both validators.
            state_in     = VAL_STATE_RESET;
            encoding_in  = verdict;
            rsp_valid_in = 1'b1;
         end else begin
            state_in = after_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= VAL_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      encoding_ff <= encoding_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_encoding = encoding_ff;

   // A valid verdict is always one of the three defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (encoding_ff != 2'd3))
      else $error("verdict carries an undefined code");

   // Accepting the last byte of a string always yields a verdict next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> rsp_valid_ff)
      else $error("last byte accepted without a verdict");

   // Both validators are rearmed after a string ends.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=>
         ((state_ff.gb_phase == PH_LEAD) && state_ff.gb_good &&
          state_ff.gbk_good && !state_ff.gbk_pending))
      else $error("validator state not rearmed after end of string");

   // A byte that does not end a string never creates a verdict.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !(req_accept && req_last_byte)) |=> !rsp_valid_ff)
      else $error("verdict appeared without a last byte");

endmodule
